FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and helper functions of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int CELL_W = 16;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic {
        CFG_FORE = 1'b0,
        CFG_BACK = 1'b1
    } t_cfg;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [COL_W-1:0] TAB_STEP = 7'd8;
    localparam logic [COL_W-1:0] TAB_MASK = 7'd7;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] line,
                                                   input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(line) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
    endfunction

    function automatic logic [CELL_W-1:0] make_cell(input logic [CLR_W-1:0] back,
                                                   input logic [CLR_W-1:0] fore,
                                                   input logic [CHAR_W-1:0] code);
        make_cell = {back, fore, code};
    endfunction

endpackage

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console engine: puts characters into a ring of screen lines held in
// one cell RAM, moves the cursor, scrolls, clears and reads screen cells.
//
//   channel   handshake            payload
//   command   start / busy         i_operation, i_char_code, i_read_row, i_read_col
//   result    o_done (strobe)      o_cursor_location, o_cell_word
//   config    i_cfg_we             i_cfg_index, i_cfg_data
//
// A put that does not scroll, or an ignored code, returns its result in the cycle
// after the transfer. A read goes through address, RAM read and result in turn.
// A scrolling put blanks one line at one RAM write per cycle. A clear writes
// every cell once. After reset the RAM is zeroed while busy is high. The
// receiver cannot stall results.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]   i_read_col,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]   i_cfg_data,
    output logic                        o_done,
    output logic [tcw_pkg::ADDR_W-1:0]  o_cursor_location,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_word
);

    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RADDR = 4'b0100,
        S_RDATA = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   r_ring, n_ring;
    logic [CLR_W-1:0]   r_fore, r_back;
    logic [ADDR_W-1:0]  r_sweep_addr, n_sweep_addr;
    logic [ADDR_W-1:0]  r_sweep_last, n_sweep_last;
    logic               r_sweep_res, n_sweep_res;
    logic               r_sweep_zero, n_sweep_zero;
    logic [ROW_W-1:0]   r_rd_line, n_rd_line;
    logic [COL_W-1:0]   r_rd_col, n_rd_col;
    logic               r_rd_ok, n_rd_ok;
    logic               r_done, n_done;
    logic [CELL_W-1:0]  r_word, n_word;
    logic [ADDR_W-1:0]  r_loc;

    logic               accept;
    t_op                op;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;
    logic [CELL_W-1:0]  blank;
    logic [COL_W-1:0]   put_col;
    logic               printable;
    logic               new_line;
    logic [ROW_W:0]     rd_diff;
    logic [ROW_W:0]     rd_sum;
    logic               rd_ok;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign op        = t_op'(i_operation);
    assign blank     = make_cell(r_back, r_fore, CH_SPACE);
    assign printable = (i_char_code >= CH_SPACE) && !i_char_code[CHAR_W-1];
    assign rd_ok     = (i_read_row < ROW_W'(SCREEN_ROWS)) &&
                       (i_read_col < COL_W'(SCREEN_COLUMNS));

    always_comb begin
        rd_diff = (r_ring >= r_row) ? ({1'b0, r_ring} - {1'b0, r_row})
                : ({1'b0, r_ring} + (ROW_W+1)'(SCREEN_ROWS) - {1'b0, r_row});
        rd_sum  = rd_diff + {1'b0, i_read_row};
    end

    always_comb begin
        put_col = r_col;
        unique case (i_char_code)
            CH_BS:   put_col = (r_col != '0) ? r_col - COL_W'(1) : r_col;
            CH_TAB:  put_col = (r_col + TAB_STEP) & ~TAB_MASK;
            CH_CR:   put_col = '0;
            default: put_col = printable ? r_col + COL_W'(1) : r_col;
        endcase
        new_line = (i_char_code == CH_LF) || (put_col >= COL_W'(SCREEN_COLUMNS));
    end

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_ring       = r_ring;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        n_sweep_res  = r_sweep_res;
        n_sweep_zero = r_sweep_zero;
        n_rd_line    = r_rd_line;
        n_rd_col     = r_rd_col;
        n_rd_ok      = r_rd_ok;
        n_done       = 1'b0;
        n_word       = '0;
        ram_we       = 1'b0;
        ram_waddr    = cell_addr(r_ring, r_col);
        ram_wdata    = make_cell(r_back, r_fore, i_char_code);
        ram_raddr    = cell_addr(r_rd_line, r_rd_col);

        unique case (r_state)
            S_SWEEP: begin
                ram_we       = 1'b1;
                ram_waddr    = r_sweep_addr;
                ram_wdata    = r_sweep_zero ? '0 : blank;
                n_sweep_addr = r_sweep_addr + ADDR_W'(1);
                if (r_sweep_addr == r_sweep_last) begin
                    n_state = S_IDLE;
                    n_done  = r_sweep_res;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_PUT: begin
                            ram_we = printable;
                            n_col  = put_col;
                            n_done = 1'b1;
                            if (new_line) begin
                                n_col  = '0;
                                n_ring = (r_ring == ROW_W'(SCREEN_ROWS - 1))
                                       ? '0 : r_ring + ROW_W'(1);
                                if (r_row == ROW_W'(SCREEN_ROWS - 1)) begin
                                    n_done       = 1'b0;
                                    n_state      = S_SWEEP;
                                    n_sweep_addr = cell_addr(n_ring, '0);
                                    n_sweep_last = cell_addr(n_ring,
                                                     COL_W'(SCREEN_COLUMNS - 1));
                                    n_sweep_res  = 1'b1;
                                    n_sweep_zero = 1'b0;
                                end else begin
                                    n_row = r_row + ROW_W'(1);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_col        = '0;
                            n_row        = '0;
                            n_ring       = '0;
                            n_state      = S_SWEEP;
                            n_sweep_addr = '0;
                            n_sweep_last = ADDR_W'(CELL_COUNT - 1);
                            n_sweep_res  = 1'b1;
                            n_sweep_zero = 1'b0;
                        end
                        OP_READ: begin
                            n_state   = S_RADDR;
                            n_rd_ok   = rd_ok;
                            n_rd_col  = rd_ok ? i_read_col : '0;
                            n_rd_line = !rd_ok ? '0
                                      : (rd_sum >= (ROW_W+1)'(SCREEN_ROWS))
                                      ? ROW_W'(rd_sum - (ROW_W+1)'(SCREEN_ROWS))
                                      : ROW_W'(rd_sum);
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_RADDR: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_word  = r_rd_ok ? ram_rdata : '0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_col        <= '0;
            r_row        <= '0;
            r_ring       <= '0;
            r_fore       <= CLR_W'(3);
            r_back       <= '0;
            r_sweep_addr <= '0;
            r_sweep_last <= ADDR_W'(CELL_COUNT - 1);
            r_sweep_res  <= 1'b0;
            r_sweep_zero <= 1'b1;
            r_rd_ok      <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_ring       <= n_ring;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_last <= n_sweep_last;
            r_sweep_res  <= n_sweep_res;
            r_sweep_zero <= n_sweep_zero;
            r_rd_ok      <= n_rd_ok;
            r_done       <= n_done;
            if (i_cfg_we) begin
                unique case (t_cfg'(i_cfg_index))
                    CFG_FORE: r_fore <= i_cfg_data;
                    CFG_BACK: r_back <= i_cfg_data;
                    default:  r_fore <= r_fore;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_line <= n_rd_line;
        r_rd_col  <= n_rd_col;
        r_word    <= n_word;
        r_loc     <= ADDR_W'(n_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(n_col);
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_done            = r_done;
    assign o_cursor_location = r_loc;
    assign o_cell_word       = r_word;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("Result strobe while the engine is not idle.");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(SCREEN_COLUMNS)) && (r_row < ROW_W'(SCREEN_ROWS)) &&
        (r_ring < ROW_W'(SCREEN_ROWS)))
        else $error("Cursor or ring line out of the screen.");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_sweep_addr <= r_sweep_last))
        else $error("Blanking sweep ran past its last cell.");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("Accepted command neither busy nor finished.");

endmodule
